// ===== hdl/bbc_pkg.sv =====
// Package for the bracket balance checker.
// Holds field widths, status and state codes, bracket characters and symbol decode.
// No dependencies.
package bbc_pkg;

	localparam int STACK_DEPTH_DFLT = 32;
	localparam int SYM_W  = 8;
	localparam int POS_W  = 16;
	localparam int STAT_W = 2;
	localparam int CODE_W = 2;

	localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [SYM_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [SYM_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [SYM_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [SYM_W-1:0] CH_RBRACE = 8'h7D;

	typedef enum logic [STAT_W-1:0] {
		ST_BALANCED   = 2'd0,
		ST_BAD_CLOSER = 2'd1,
		ST_MISSING    = 2'd2,
		ST_OVERFLOW   = 2'd3
	} status_t;

	typedef enum logic [CODE_W-1:0] {
		BR_PAREN = 2'd0,
		BR_BRACK = 2'd1,
		BR_BRACE = 2'd2,
		BR_NONE  = 2'd3
	} bracket_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_CHECK,
		FSM_EMIT,
		FSM_DRAIN_RD,
		FSM_DRAIN_OUT
	} fsm_t;

	typedef struct packed {
		logic     is_open;
		logic     is_close;
		bracket_t code;
	} sym_class_t;

	function automatic sym_class_t classify(input logic [SYM_W-1:0] sym);
		sym_class_t c;
		c.is_open  = 1'b0;
		c.is_close = 1'b0;
		c.code     = BR_NONE;
		unique case (sym)
			CH_LPAREN: begin c.is_open  = 1'b1; c.code = BR_PAREN; end
			CH_LBRACK: begin c.is_open  = 1'b1; c.code = BR_BRACK; end
			CH_LBRACE: begin c.is_open  = 1'b1; c.code = BR_BRACE; end
			CH_RPAREN: begin c.is_close = 1'b1; c.code = BR_PAREN; end
			CH_RBRACK: begin c.is_close = 1'b1; c.code = BR_BRACK; end
			CH_RBRACE: begin c.is_close = 1'b1; c.code = BR_BRACE; end
			default: begin end
		endcase
		return c;
	endfunction

	function automatic logic [SYM_W-1:0] closer_char(input logic [CODE_W-1:0] code);
		logic [SYM_W-1:0] ch;
		ch = '0;
		unique case (code)
			BR_PAREN: ch = CH_RPAREN;
			BR_BRACK: ch = CH_RBRACK;
			BR_BRACE: ch = CH_RBRACE;
			default:  ch = '0;
		endcase
		return ch;
	endfunction

endpackage

// ===== hdl/bbc_if.sv =====
// Valid/ready channels of the bracket balance checker: character items in, report items out.
// Depends on bbc_pkg for the field widths.
interface bbc_char_if;
	logic                       valid;
	logic                       ready;
	logic [bbc_pkg::SYM_W-1:0]  symbol;
	logic                       end_of_string;

	modport source (output valid, symbol, end_of_string, input ready);
	modport sink   (input valid, symbol, end_of_string, output ready);
endinterface

interface bbc_rpt_if;
	logic                       valid;
	logic                       ready;
	logic [bbc_pkg::STAT_W-1:0] status;
	logic [bbc_pkg::POS_W-1:0]  position;
	logic [bbc_pkg::SYM_W-1:0]  char_out;
	logic                       last;

	modport source (output valid, status, position, char_out, last, input ready);
	modport sink   (input valid, status, position, char_out, last, output ready);
endinterface

// ===== hdl/bracket_balance_checker.sv =====
// Bracket balance checker: opener stack in a synchronous memory, one read port.
// Depends on bbc_pkg and the channels in bbc_if.sv.
// Plain characters and openers are taken while idle; a closer also passes a check state
// for its stack read. Results go via the emit or drain-out state to the output register.
// End-of-string drain of leftover openers: one result per cycle unless the output stalls,
// bounded by the single stack read port. Input stalls in closer checks, emits and drains.
// Reset clears the FSM, counters and output valid; the stack memory is not cleared.
module bracket_balance_checker #(
	parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DFLT
) (
	input  logic          clk,
	input  logic          arst_n,
	bbc_char_if.sink      chars,
	bbc_rpt_if.source     report
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [bbc_pkg::CODE_W-1:0] stack_mem [STACK_DEPTH];
	logic [bbc_pkg::CODE_W-1:0] rd_q;

	bbc_pkg::fsm_t    state_q, state_d;
	logic [CW-1:0]    count_q, count_d, count_m1;
	logic             err_q, err_d;
	logic [bbc_pkg::POS_W-1:0] idx_q, idx_d;
	bbc_pkg::status_t pend_q, pend_d;

	logic [bbc_pkg::SYM_W-1:0] sym_s1;
	logic                      eos_s1;
	logic [bbc_pkg::POS_W-1:0] pos_s1;

	logic                       out_valid_q;
	bbc_pkg::status_t           out_status_q, out_status_d;
	logic [bbc_pkg::POS_W-1:0]  out_pos_q, out_pos_d;
	logic [bbc_pkg::SYM_W-1:0]  out_char_q, out_char_d;
	logic                       out_last_q, out_last_d;
	logic                       out_load, out_free;

	logic                       mem_we, mem_re;
	logic [AW-1:0]              mem_waddr, mem_raddr;
	logic [bbc_pkg::CODE_W-1:0] mem_wdata;

	logic                       accept, full, empty;
	bbc_pkg::sym_class_t        in_cls, s1_cls;

	assign accept   = chars.valid && chars.ready;
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign empty    = (count_q == '0);
	assign count_m1 = count_q - 1'b1;
	assign out_free = !out_valid_q || report.ready;
	assign in_cls   = bbc_pkg::classify(chars.symbol);
	assign s1_cls   = bbc_pkg::classify(sym_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbc_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		err_d        = err_q;
		idx_d        = idx_q;
		pend_d       = pend_q;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_waddr    = count_q[AW-1:0];
		mem_raddr    = count_m1[AW-1:0];
		mem_wdata    = in_cls.code;
		out_load     = 1'b0;
		out_status_d = pend_q;
		out_pos_d    = pos_s1;
		out_char_d   = sym_s1;
		out_last_d   = 1'b1;
		chars.ready  = 1'b0;

		unique case (state_q)
			bbc_pkg::FSM_IDLE: begin
				chars.ready = 1'b1;
				if (chars.valid) begin
					if (chars.end_of_string) begin
						idx_d = '0;
					end else if (idx_q != '1) begin
						idx_d = idx_q + 1'b1;
					end
					if (err_q) begin
						if (chars.end_of_string) begin
							err_d   = 1'b0;
							count_d = '0;
						end
					end else if (in_cls.is_open) begin
						if (full) begin
							pend_d  = bbc_pkg::ST_OVERFLOW;
							err_d   = !chars.end_of_string;
							if (chars.end_of_string) begin
								count_d = '0;
							end
							state_d = bbc_pkg::FSM_EMIT;
						end else begin
							mem_we  = 1'b1;
							count_d = count_q + 1'b1;
							if (chars.end_of_string) begin
								state_d = bbc_pkg::FSM_DRAIN_RD;
							end
						end
					end else if (in_cls.is_close) begin
						if (empty) begin
							pend_d  = bbc_pkg::ST_BAD_CLOSER;
							err_d   = !chars.end_of_string;
							state_d = bbc_pkg::FSM_EMIT;
						end else begin
							mem_re  = 1'b1;
							count_d = count_m1;
							state_d = bbc_pkg::FSM_CHECK;
						end
					end else if (chars.end_of_string) begin
						if (empty) begin
							pend_d  = bbc_pkg::ST_BALANCED;
							state_d = bbc_pkg::FSM_EMIT;
						end else begin
							state_d = bbc_pkg::FSM_DRAIN_RD;
						end
					end
				end
			end
			bbc_pkg::FSM_CHECK: begin
				if (rd_q != s1_cls.code) begin
					pend_d  = bbc_pkg::ST_BAD_CLOSER;
					err_d   = !eos_s1;
					if (eos_s1) begin
						count_d = '0;
					end
					state_d = bbc_pkg::FSM_EMIT;
				end else if (eos_s1) begin
					if (empty) begin
						pend_d  = bbc_pkg::ST_BALANCED;
						state_d = bbc_pkg::FSM_EMIT;
					end else begin
						state_d = bbc_pkg::FSM_DRAIN_RD;
					end
				end else begin
					state_d = bbc_pkg::FSM_IDLE;
				end
			end
			bbc_pkg::FSM_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (pend_q == bbc_pkg::ST_BALANCED) begin
						out_pos_d  = '0;
						out_char_d = '0;
					end
					state_d = bbc_pkg::FSM_IDLE;
				end
			end
			bbc_pkg::FSM_DRAIN_RD: begin
				mem_re  = 1'b1;
				count_d = count_m1;
				state_d = bbc_pkg::FSM_DRAIN_OUT;
			end
			bbc_pkg::FSM_DRAIN_OUT: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = bbc_pkg::ST_MISSING;
					out_pos_d    = '0;
					out_char_d   = bbc_pkg::closer_char(rd_q);
					out_last_d   = empty;
					if (empty) begin
						state_d = bbc_pkg::FSM_IDLE;
					end else begin
						mem_re  = 1'b1;
						count_d = count_m1;
					end
				end
			end
			default: state_d = bbc_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			err_q   <= err_d;
			idx_q   <= idx_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (accept) begin
			sym_s1 <= chars.symbol;
			eos_s1 <= chars.end_of_string;
			pos_s1 <= idx_q;
		end
		if (out_load) begin
			out_status_q <= out_status_d;
			out_pos_q    <= out_pos_d;
			out_char_q   <= out_char_d;
			out_last_q   <= out_last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= stack_mem[mem_raddr];
		end
	end

	assign report.valid    = out_valid_q;
	assign report.status   = out_status_q;
	assign report.position = out_pos_q;
	assign report.char_out = out_char_q;
	assign report.last     = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_drain_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbc_pkg::FSM_DRAIN_RD || state_q == bbc_pkg::FSM_DRAIN_OUT) |-> !err_q)
		else $error("drain after an error");

	a_last_only_missing: assert property (@(posedge clk) disable iff (!arst_n)
		(report.valid && !report.last) |-> report.status == bbc_pkg::ST_MISSING)
		else $error("non-final result that is not a missing closer");

	a_check_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bbc_pkg::FSM_CHECK |-> count_q < CW'(STACK_DEPTH))
		else $error("closer check without a pop");

	a_err_blocks_results: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbc_pkg::FSM_IDLE && err_q) |=> !out_load)
		else $error("result after an error in the same string");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for bracket_balance_checker: character strings in, bracket reports out.
// Depends on bbc_pkg and the bbc_char_if / bbc_rpt_if channel interfaces.
`timescale 1ns / 100ps

module tb_top;

	localparam int DEPTH       = bbc_pkg::STACK_DEPTH_DFLT;
	localparam int RAND_LIVE   = 370;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE      = 40;
	localparam int SHAPE_WELL     = 0;
	localparam int SHAPE_LEFTOVER = 1;
	localparam int SHAPE_BROKEN   = 2;

	typedef struct {
		logic [bbc_pkg::SYM_W-1:0] symbol;
		logic                      eos;
		bit                        hold;
	} char_item_t;

	typedef struct {
		bbc_pkg::status_t          status;
		logic [bbc_pkg::POS_W-1:0] position;
		logic [bbc_pkg::SYM_W-1:0] char_out;
		logic                      last;
	} report_t;

	logic clk;
	logic arst_n;

	bbc_char_if chars ();
	bbc_rpt_if  report ();

	bracket_balance_checker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.report (report)
	);

	char_item_t                char_q[$];
	report_t                   owed_reports[$];
	logic [bbc_pkg::SYM_W-1:0] text[$];
	char_item_t                next_char;
	report_t                   head_report;

	bbc_pkg::bracket_t         opener_stk[DEPTH];
	int unsigned               open_depth;
	logic [bbc_pkg::POS_W-1:0] char_pos;
	bit                        swallowing;

	int  mismatches;
	int  n_chars;
	int  live_items;
	int  idle_cycles;
	bit  reports_busy;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit rand_idle();
		if (n_chars >= 120 && n_chars < 260)
			return 1'b0;
		return $urandom_range(99) < 35;
	endfunction

	function automatic logic [bbc_pkg::SYM_W-1:0] open_ch(bbc_pkg::bracket_t b);
		case (b)
			bbc_pkg::BR_PAREN: return bbc_pkg::CH_LPAREN;
			bbc_pkg::BR_BRACK: return bbc_pkg::CH_LBRACK;
			default:           return bbc_pkg::CH_LBRACE;
		endcase
	endfunction

	function automatic logic [bbc_pkg::SYM_W-1:0] close_ch(bbc_pkg::bracket_t b);
		case (b)
			bbc_pkg::BR_PAREN: return bbc_pkg::CH_RPAREN;
			bbc_pkg::BR_BRACK: return bbc_pkg::CH_RBRACK;
			default:           return bbc_pkg::CH_RBRACE;
		endcase
	endfunction

	function automatic logic [bbc_pkg::SYM_W-1:0] plain_byte();
		logic [bbc_pkg::SYM_W-1:0] b;
		do
			b = bbc_pkg::SYM_W'($urandom_range(255));
		while (b inside {bbc_pkg::CH_LPAREN, bbc_pkg::CH_RPAREN, bbc_pkg::CH_LBRACK,
				bbc_pkg::CH_RBRACK, bbc_pkg::CH_LBRACE, bbc_pkg::CH_RBRACE});
		return b;
	endfunction

	function automatic void owe(bbc_pkg::status_t st, logic [bbc_pkg::POS_W-1:0] pos,
			logic [bbc_pkg::SYM_W-1:0] ch, logic lst);
		report_t r;
		r.status   = st;
		r.position = pos;
		r.char_out = ch;
		r.last     = lst;
		owed_reports.push_back(r);
	endfunction

	function automatic void track_brackets(logic [bbc_pkg::SYM_W-1:0] sym, logic eos);
		bbc_pkg::bracket_t         code;
		logic                      opener;
		logic                      closer;
		logic [bbc_pkg::POS_W-1:0] at;
		at = char_pos;
		if (char_pos != '1)
			char_pos++;
		opener = 1'b0;
		closer = 1'b0;
		code   = bbc_pkg::BR_NONE;
		case (sym)
			bbc_pkg::CH_LPAREN: begin opener = 1'b1; code = bbc_pkg::BR_PAREN; end
			bbc_pkg::CH_LBRACK: begin opener = 1'b1; code = bbc_pkg::BR_BRACK; end
			bbc_pkg::CH_LBRACE: begin opener = 1'b1; code = bbc_pkg::BR_BRACE; end
			bbc_pkg::CH_RPAREN: begin closer = 1'b1; code = bbc_pkg::BR_PAREN; end
			bbc_pkg::CH_RBRACK: begin closer = 1'b1; code = bbc_pkg::BR_BRACK; end
			bbc_pkg::CH_RBRACE: begin closer = 1'b1; code = bbc_pkg::BR_BRACE; end
			default: begin end
		endcase
		if (!swallowing) begin
			if (opener) begin
				if (open_depth >= DEPTH) begin
					owe(bbc_pkg::ST_OVERFLOW, at, sym, 1'b1);
					swallowing = 1'b1;
				end else begin
					opener_stk[open_depth] = code;
					open_depth++;
				end
			end else if (closer) begin
				if (open_depth == 0) begin
					owe(bbc_pkg::ST_BAD_CLOSER, at, sym, 1'b1);
					swallowing = 1'b1;
				end else begin
					open_depth--;
					if (opener_stk[open_depth] != code) begin
						owe(bbc_pkg::ST_BAD_CLOSER, at, sym, 1'b1);
						swallowing = 1'b1;
					end
				end
			end
			if (eos && !swallowing) begin
				if (open_depth == 0) begin
					owe(bbc_pkg::ST_BALANCED, '0, '0, 1'b1);
				end else begin
					while (open_depth > 0) begin
						open_depth--;
						owe(bbc_pkg::ST_MISSING, '0, close_ch(opener_stk[open_depth]),
							open_depth == 0);
					end
				end
			end
		end
		if (eos) begin
			open_depth = 0;
			char_pos   = '0;
			swallowing = 1'b0;
		end
	endfunction

	task automatic note_mismatch(string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endtask

	task automatic send_text(bit hold);
		char_item_t it;
		for (int i = 0; i < text.size(); i++) begin
			it.symbol = text[i];
			it.eos    = (i == text.size() - 1);
			it.hold   = hold && (i == 0);
			live_items++;
			char_q.push_back(it);
		end
		text.delete();
	endtask

	task automatic gen_nested(int steps, int shape, bit hold);
		bbc_pkg::bracket_t opens[$];
		bbc_pkg::bracket_t b;
		int                bad_at;
		bad_at = (shape == SHAPE_BROKEN) ? $urandom_range(steps - 1) : -1;
		for (int i = 0; i < steps; i++) begin
			if (i == bad_at) begin
				if (opens.size() == 0) begin
					text.push_back(close_ch(bbc_pkg::bracket_t'($urandom_range(2))));
				end else begin
					b = opens.pop_back();
					text.push_back(close_ch(bbc_pkg::bracket_t'((b + 1 + $urandom_range(1)) % 3)));
				end
			end else begin
				case ($urandom_range(2))
					0: begin
						b = bbc_pkg::bracket_t'($urandom_range(2));
						opens.push_back(b);
						text.push_back(open_ch(b));
					end
					1: begin
						if (opens.size() != 0)
							text.push_back(close_ch(opens.pop_back()));
						else
							text.push_back(plain_byte());
					end
					default: text.push_back(plain_byte());
				endcase
			end
		end
		if (shape != SHAPE_LEFTOVER)
			while (opens.size() != 0)
				text.push_back(close_ch(opens.pop_back()));
		if (text.size() == 0)
			text.push_back(plain_byte());
		send_text(hold);
	endtask

	task automatic gen_deep(int n, bit close_all, bit hold);
		bbc_pkg::bracket_t opens[$];
		bbc_pkg::bracket_t b;
		for (int i = 0; i < n; i++) begin
			b = bbc_pkg::bracket_t'($urandom_range(2));
			opens.push_back(b);
			text.push_back(open_ch(b));
		end
		if (close_all) begin
			while (opens.size() != 0)
				text.push_back(close_ch(opens.pop_back()));
			text.push_back(plain_byte());
		end
		send_text(hold);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars.valid         <= 1'b0;
			chars.symbol        <= '0;
			chars.end_of_string <= 1'b0;
		end else if (!chars.valid || chars.ready) begin
			if (char_q.size() != 0 && !(char_q[0].hold && (chars.valid || reports_busy))
					&& !rand_idle()) begin
				next_char = char_q.pop_front();
				chars.symbol        <= next_char.symbol;
				chars.end_of_string <= next_char.eos;
				chars.valid         <= 1'b1;
			end else begin
				chars.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report.ready <= 1'b0;
			reports_busy <= 1'b0;
		end else begin
			if (chars.valid && chars.ready) begin
				track_brackets(chars.symbol, chars.end_of_string);
				n_chars <= n_chars + 1;
			end
			if (report.valid && report.ready) begin
				if (owed_reports.size() == 0) begin
					note_mismatch($sformatf("unexpected report %0d/%0d/%02h/%0b",
						report.status, report.position, report.char_out, report.last));
				end else begin
					head_report = owed_reports.pop_front();
					if (report.status !== head_report.status
							|| report.position !== head_report.position
							|| report.char_out !== head_report.char_out
							|| report.last !== head_report.last)
						note_mismatch($sformatf("report got %0d/%0d/%02h/%0b want %0d/%0d/%02h/%0b",
							report.status, report.position, report.char_out, report.last,
							head_report.status, head_report.position, head_report.char_out,
							head_report.last));
				end
			end
			report.ready <= !rand_idle();
			reports_busy <= (owed_reports.size() != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((chars.valid && chars.ready) || (report.valid && report.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		chars.valid         = 1'b0;
		chars.symbol        = '0;
		chars.end_of_string = 1'b0;
		report.ready        = 1'b0;
		arst_n              = 1'b0;
		mismatches  = 0;
		n_chars     = 0;
		live_items  = 0;
		idle_cycles = 0;
		open_depth  = 0;
		char_pos    = '0;
		swallowing  = 1'b0;

		add_str("()");     send_text(1'b0);
		add_str("([{}])"); send_text(1'b0);
		add_str(")");      send_text(1'b0);
		add_str("(]");     send_text(1'b0);
		add_str("{x)y");   send_text(1'b0);
		add_str("[{(");    send_text(1'b0);
		add_str("a");      send_text(1'b0);
		text.push_back(8'hFF); send_text(1'b0);
		text.push_back(8'h00); send_text(1'b0);

		live_items = 0;
		gen_deep(DEPTH, 1'b0, 1'b1);
		gen_deep(DEPTH, 1'b1, 1'b0);
		gen_deep(DEPTH + 1, 1'b0, 1'b0);
		while (live_items < RAND_LIVE) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: gen_nested($urandom_range(1, 14), SHAPE_WELL, $urandom_range(11) == 0);
				5, 6:          gen_nested($urandom_range(1, 14), SHAPE_LEFTOVER, 1'b0);
				7:             gen_nested($urandom_range(1, 10), SHAPE_BROKEN, 1'b0);
				8: begin
					repeat ($urandom_range(1, 6))
						text.push_back(bbc_pkg::SYM_W'($urandom_range(255)));
					send_text(1'b0);
				end
				default: gen_deep($urandom_range(DEPTH - 1, DEPTH + 2),
					$urandom_range(1) != 0, 1'b0);
			endcase
		end

		text.push_back(bbc_pkg::CH_LPAREN);
		text.push_back(bbc_pkg::CH_RBRACK);
		text.push_back(plain_byte());
		send_text(1'b0);
		add_str(")");
		send_text(1'b0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (char_q.size() != 0 || chars.valid || owed_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
